@@ src/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and codes of the text console cell engine
// Cell type, operation codes, control characters and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

   typedef logic [15:0] cell_type;
   typedef logic [7:0]  byte_type;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam byte_type CH_NEWLINE   = 8'd10;
   localparam byte_type CH_TAB       = 8'd9;
   localparam byte_type CH_BACKSPACE = 8'd8;
   localparam byte_type CH_SPACE     = 8'h20;

   localparam logic [3:0] CLEAR_FG          = 4'h7;
   localparam logic [3:0] RESET_BG          = 4'h0;
   localparam byte_type   BLANK_ATTR_RESET  = 8'h07;

endpackage : tcce_pkg

`default_nettype wire

@@ src/tcce_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcce_cell_ram: screen cell store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cell_ram
   import tcce_pkg::*;
#(
   parameter int unsigned DEPTH  = 2000,
   parameter int unsigned ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire cell_type          wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output cell_type               rd_data
);

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : tcce_cell_ram

`default_nettype wire

@@ src/tcce_seq.sv @@
// ----------------------------------------------------------------------------
// tcce_seq: operation sequencer of the text console cell engine
// Holds the cursor and steps the cell store through put, read, scroll and fill.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_seq
   import tcce_pkg::*;
#(
   parameter int unsigned COLUMNS    = 80,
   parameter int unsigned ROWS       = 25,
   parameter int unsigned TAB_SPACES = 4,
   parameter int unsigned COL_W      = 7,
   parameter int unsigned ROW_W      = 5,
   parameter int unsigned ADDR_W     = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        opcode,
   input  wire byte_type          char_code,
   input  wire byte_type          attribute,
   input  wire logic [3:0]        background,
   input  wire logic [10:0]       cell_index,
   input  wire byte_type          blank_attribute,
   output logic                   busy,
   output logic                   rsp_valid,
   output cell_type               rsp_cell_data,
   output logic [COL_W-1:0]       cur_col,
   output logic [ROW_W-1:0]       cur_row,
   output logic [ADDR_W-1:0]      cur_addr,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output cell_type               wr_data,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire cell_type          rd_data
);

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned PTR_W = $clog2(CELLS + 1);
   localparam int unsigned CNT_W = $clog2(TAB_SPACES + 1);

   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
   localparam logic [PTR_W-1:0]  PTR_COLS    = PTR_W'(COLUMNS);
   localparam logic [PTR_W-1:0]  PTR_COLS_P1 = PTR_W'(COLUMNS + 1);
   localparam logic [PTR_W-1:0]  PTR_CELLS   = PTR_W'(CELLS);
   localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(CELLS - 1);
   localparam logic [PTR_W-1:0]  PTR_BOTTOM  = PTR_W'(CELLS - COLUMNS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLAIN,
      S_BLANK,
      S_READ,
      S_SCROLL,
      S_FILL
   } state_type;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cell_type         cell_ff, cell_in;
   logic             silent_ff, silent_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cell_type         rsp_data_ff, rsp_data_in;
   cell_type         blank;
   logic             last_word;

   assign blank    = {blank_attribute, CH_SPACE};
   assign cur_addr = ADDR_W'(ADDR_W'(row_ff) * COLS_A) + ADDR_W'(col_ff);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      cell_in      = cell_ff;
      silent_in    = silent_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = cell_ff;
      rd_addr      = cur_addr;
      last_word    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_data_in = '0;
               case (opcode)
                  OP_PUT: begin
                     case (char_code)
                        CH_NEWLINE: begin
                           col_in = '0;
                           if (row_ff < ROW_LAST) begin
                              row_in       = row_ff + ROW_W'(1);
                              rsp_valid_in = 1'b1;
                           end else begin
                              ptr_in   = PTR_COLS;
                              cnt_in   = '0;
                              state_in = S_SCROLL;
                           end
                        end
                        CH_TAB: begin
                           cell_in  = blank;
                           cnt_in   = CNT_W'(TAB_SPACES);
                           state_in = S_PLAIN;
                        end
                        CH_BACKSPACE: begin
                           if (col_ff != '0) begin
                              col_in = col_ff - COL_W'(1);
                           end
                           cell_in  = blank;
                           state_in = S_BLANK;
                        end
                        default: begin
                           cell_in  = {attribute, char_code};
                           cnt_in   = CNT_W'(1);
                           state_in = S_PLAIN;
                        end
                     endcase
                  end
                  OP_CLEAR: begin
                     cell_in  = {background, CLEAR_FG, CH_SPACE};
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  OP_READ: begin
                     if ({21'd0, cell_index} < 32'(CELLS)) begin
                        rd_addr  = ADDR_W'(cell_index);
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_PLAIN: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (col_ff < COL_LAST) begin
               col_in    = col_ff + COL_W'(1);
               last_word = (cnt_ff == CNT_W'(1));
            end else begin
               col_in = '0;
               if (row_ff < ROW_LAST) begin
                  row_in    = row_ff + ROW_W'(1);
                  last_word = (cnt_ff == CNT_W'(1));
               end else begin
                  ptr_in   = PTR_COLS;
                  state_in = S_SCROLL;
               end
            end
            if (last_word) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_BLANK: begin
            wr_en        = 1'b1;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_READ: begin
            rsp_data_in  = rd_data;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_SCROLL: begin
            // read one row down, write back the registered word from the read before it
            rd_addr = ADDR_W'(ptr_ff);
            wr_addr = ADDR_W'(ptr_ff - PTR_COLS_P1);
            wr_data = rd_data;
            wr_en   = (ptr_ff > PTR_COLS);
            ptr_in  = ptr_ff + PTR_W'(1);
            if (ptr_ff == PTR_CELLS) begin
               ptr_in   = PTR_BOTTOM;
               cell_in  = blank;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(ptr_ff);
            ptr_in  = ptr_ff + PTR_W'(1);
            if (ptr_ff == PTR_LAST) begin
               silent_in = 1'b0;
               if (silent_ff) begin
                  state_in = S_IDLE;
               end else if (cnt_ff != '0) begin
                  state_in = S_PLAIN;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         cell_ff      <= {RESET_BG, CLEAR_FG, CH_SPACE};
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         cell_ff      <= cell_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_data = rsp_data_ff;
   assign cur_col       = col_ff;
   assign cur_row       = row_ff;

   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response word issued while sequencer busy");

   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS))
      else $error("cursor outside the screen");

   a_scroll_ptr : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) |-> ((ptr_ff >= PTR_COLS) && (ptr_ff <= PTR_CELLS)))
      else $error("scroll pointer outside its sweep");

   a_write_range : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < CELLS))
      else $error("cell write beyond the store");

   a_silent_fill : assert property (@(posedge clock) disable iff (reset)
      silent_ff |-> (state_ff == S_FILL))
      else $error("reset clearing pass left the fill state early");

endmodule : tcce_seq

`default_nettype wire

@@ src/text_console_cell_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_engine: text console cell store with cursor
// Put, clear and read operations on a COLUMNS x ROWS store of 16-bit cells.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  --------------------------
//   request  req_opcode .. req_cell_index            start high, busy low
//   result   rsp_cell_data, rsp_cursor_*             rsp_valid strobe, 1 cycle
//   csr      csr_wdata (blank_attribute)             csr_valid and csr_ready
//
// Sequencing: a printable put and a backspace write one cell, and an in-range
// read waits for the registered read data; a newline without scroll, a read
// past the store and the unused opcode answer straight from idle; a tab
// writes TAB_SPACES cells. Clear and each scroll sweep the whole store
// through the single write port of the cell store, one cell per cycle.
// Reset: a clearing pass blanks the store; busy stays high meanwhile. The
// result strobe cannot be stalled; csr words are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_engine
   import tcce_pkg::*;
#(
   parameter int unsigned COLUMNS    = 80,
   parameter int unsigned ROWS       = 25,
   parameter int unsigned TAB_SPACES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [7:0]  req_attribute,
   input  wire logic [3:0]  req_background,
   input  wire logic [10:0] req_cell_index,
   output logic             rsp_valid,
   output logic [15:0]      rsp_cell_data,
   output logic [6:0]       rsp_cursor_col,
   output logic [4:0]       rsp_cursor_row,
   output logic [10:0]      rsp_cursor_offset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_wdata
);

   localparam int unsigned CELLS  = COLUMNS * ROWS;
   localparam int unsigned COL_W  = $clog2(COLUMNS);
   localparam int unsigned ROW_W  = $clog2(ROWS);
   localparam int unsigned ADDR_W = $clog2(CELLS);

   // blank attribute register; always ready to take a word
   byte_type blank_attr_ff;

   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [ADDR_W-1:0] cur_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   cell_type          wr_data;
   logic [ADDR_W-1:0] rd_addr;
   cell_type          rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= BLANK_ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         blank_attr_ff <= csr_wdata;
      end
   end

   // sequencer: cursor, operation decode, scroll and fill sweeps
   tcce_seq #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .TAB_SPACES (TAB_SPACES),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W),
      .ADDR_W     (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .opcode          (req_opcode),
      .char_code       (req_char_code),
      .attribute       (req_attribute),
      .background      (req_background),
      .cell_index      (req_cell_index),
      .blank_attribute (blank_attr_ff),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_cell_data   (rsp_cell_data),
      .cur_col         (cur_col),
      .cur_row         (cur_row),
      .cur_addr        (cur_addr),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   // cell store
   tcce_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // cursor stays put during the strobe cycle; mask to the port widths
   assign rsp_cursor_col    = 7'(cur_col);
   assign rsp_cursor_row    = 5'(cur_row);
   assign rsp_cursor_offset = 11'(cur_addr);

endmodule : text_console_cell_engine

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console cell engine
// Walks a short table of directed words (reset contents, field extremes,
// control characters, clear, scroll), then random runs of text, newlines,
// reads and clears under several blank attributes and sender idle rates.
// Every result word is compared with a shadow prediction or a typed value.
// ----------------------------------------------------------------------------

module testbench
   import tcce_pkg::*;
;

   localparam int unsigned COLS         = 80;
   localparam int unsigned ROWS         = 25;
   localparam int unsigned TAB_WIDTH    = 4;
   localparam int unsigned CELLS        = COLS * ROWS;
   localparam int unsigned QUIET_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 10_000_000;

   // opcode 3 has no operation behind it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      byte_type    char_code;
      byte_type    attribute;
      logic [3:0]  background;
      logic [10:0] cell_index;
   } command_type;

   typedef struct packed {
      cell_type    cell_data;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] offset;
   } report_type;

   // per issued word: whether a hand-typed result replaces the prediction
   typedef struct packed {
      logic       typed;
      report_type want;
   } guide_type;

   typedef struct packed {
      command_type cmd;
      int unsigned reps;
      logic        typed;
      report_type  want;
   } script_row_type;

   // ---------------------------------------------------------------- signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode     = '0;
   logic [7:0]  req_char_code  = '0;
   logic [7:0]  req_attribute  = '0;
   logic [3:0]  req_background = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic [15:0] rsp_cell_data;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata = '0;

   text_console_cell_engine dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_attribute     (req_attribute),
      .req_background    (req_background),
      .req_cell_index    (req_cell_index),
      .rsp_valid         (rsp_valid),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   // 20 ns period
   always #10 clock = ~clock;

   // ------------------------------------------------------- shadow console
   cell_type    screen_shadow [CELLS];
   int unsigned shadow_col;
   int unsigned shadow_row;
   byte_type    shadow_blank;

   report_type     due_reports [$];   // results still to arrive, oldest first
   guide_type      guide_q [$];       // one entry per word handed to the driver
   script_row_type script [$];
   int unsigned words_issued = 0;
   int unsigned results_seen = 0;
   int unsigned errors       = 0;
   int unsigned cycle_count  = 0;

   function automatic cell_type blank_cell();
      return {shadow_blank, CH_SPACE};
   endfunction

   // Move down one row; on the last row shift the whole store up instead.
   function automatic void advance_row();
      int unsigned i;
      if (shadow_row < ROWS - 1) begin
         shadow_row++;
      end else begin
         for (i = 0; i < CELLS - COLS; i++)
            screen_shadow[i] = screen_shadow[i + COLS];
         for (i = CELLS - COLS; i < CELLS; i++)
            screen_shadow[i] = blank_cell();
      end
   endfunction

   // Write at the cursor and step right, wrapping after the last column.
   function automatic void store_and_step(cell_type c);
      screen_shadow[shadow_row * COLS + shadow_col] = c;
      if (shadow_col < COLS - 1) begin
         shadow_col++;
      end else begin
         shadow_col = 0;
         advance_row();
      end
   endfunction

   function automatic report_type apply_console_op(command_type c);
      report_type  r;
      int unsigned i;
      r.cell_data = '0;
      case (c.opcode)
         OP_PUT: begin
            if (c.char_code == CH_NEWLINE) begin
               shadow_col = 0;
               advance_row();
            end else if (c.char_code == CH_TAB) begin
               for (i = 0; i < TAB_WIDTH; i++)
                  store_and_step(blank_cell());
            end else if (c.char_code == CH_BACKSPACE) begin
               if (shadow_col > 0)
                  shadow_col--;
               screen_shadow[shadow_row * COLS + shadow_col] = blank_cell();
            end else begin
               store_and_step({c.attribute, c.char_code});
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               screen_shadow[i] = {c.background, CLEAR_FG, CH_SPACE};
            shadow_col = 0;
            shadow_row = 0;
         end
         OP_READ: begin
            if (c.cell_index < CELLS)
               r.cell_data = screen_shadow[c.cell_index];
         end
         default: begin
         end
      endcase
      r.col    = 7'(shadow_col);
      r.row    = 5'(shadow_row);
      r.offset = 11'(shadow_row * COLS + shadow_col);
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // ------------------------------------------------------------- monitor
   // Track accepted words and csr writes in one process, so the shadow
   // state and the result queue advance in a fixed order within each edge.
   always @(posedge clock) begin : watch_ports
      command_type cmd;
      report_type  guess;
      report_type  got;
      report_type  want;
      guide_type   guide;
      int unsigned i;
      if (reset) begin
         for (i = 0; i < CELLS; i++)
            screen_shadow[i] = {RESET_BG, CLEAR_FG, CH_SPACE};
         shadow_col   = 0;
         shadow_row   = 0;
         shadow_blank = BLANK_ATTR_RESET;
      end else begin
         if (csr_valid && csr_ready)
            shadow_blank = csr_wdata;
         // push before checking, so a same-edge result still finds its entry
         if (start && !busy) begin
            cmd   = {req_opcode, req_char_code, req_attribute, req_background,
                     req_cell_index};
            guess = apply_console_op(cmd);
            guide = (guide_q.size() != 0) ? guide_q.pop_front() : '0;
            due_reports.push_back(guide.typed ? guide.want : guess);
         end
         if (rsp_valid) begin
            results_seen++;
            got = {rsp_cell_data, rsp_cursor_col, rsp_cursor_row, rsp_cursor_offset};
            if (due_reports.size() == 0) begin
               $error("result word with nothing expected: data 0x%0h", rsp_cell_data);
               errors++;
            end else begin
               want = due_reports.pop_front();
               check_field("cell_data", want.cell_data, got.cell_data);
               check_field("cursor_col", 16'(want.col), 16'(got.col));
               check_field("cursor_row", 16'(want.row), 16'(got.row));
               check_field("cursor_offset", 16'(want.offset), 16'(got.offset));
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------- driver
   // Present one word and hold it until accepted. With idle_pct set, drop
   // start afterwards for a random stretch; otherwise keep start high so the
   // next word follows back to back.
   task automatic issue(command_type c, logic typed, report_type want,
                        int unsigned idle_pct);
      guide_q.push_back({typed, want});
      req_opcode     <= c.opcode;
      req_char_code  <= c.char_code;
      req_attribute  <= c.attribute;
      req_background <= c.background;
      req_cell_index <= c.cell_index;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      words_issued++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Drop start and wait until every issued word has answered and the
   // engine has finished any scroll or clear still in flight.
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (results_seen < words_issued || busy);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_blank_attr(byte_type value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic add_step(logic [1:0] op, byte_type ch, byte_type attr, logic [3:0] bg,
                           logic [10:0] idx, int unsigned reps, logic typed,
                           cell_type data, int unsigned col, int unsigned row);
      script_row_type s;
      s.cmd       = {op, ch, attr, bg, idx};
      s.reps      = reps;
      s.typed     = typed;
      s.want      = {data, 7'(col), 5'(row), 11'(row * COLS + col)};
      script.push_back(s);
   endtask

   // Random traffic in runs: text lines, newline bursts (to reach the bottom
   // row and scroll), reads (half near the cursor), tabs, backspaces, clears.
   task automatic run_traffic(int unsigned items, int unsigned idle_pct, logic hold_mid);
      command_type c;
      int unsigned sent;
      int unsigned kind;
      int unsigned run_len;
      int unsigned k;
      int unsigned pick;
      int unsigned base;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(99);
         if (kind < 40)      run_len = $urandom_range(100, 1);
         else if (kind < 62) run_len = $urandom_range(24, 1);
         else if (kind < 82) run_len = $urandom_range(8, 1);
         else if (kind < 86) run_len = $urandom_range(4, 1);
         else if (kind < 90) run_len = $urandom_range(6, 1);
         else if (kind < 96) run_len = 1;
         else                run_len = $urandom_range(2, 1);
         for (k = 0; k < run_len && sent < items; k++) begin
            // randomize every field, then force what the run needs
            c.char_code  = 8'($urandom);
            c.attribute  = 8'($urandom);
            c.background = 4'($urandom);
            c.cell_index = 11'($urandom);
            c.opcode     = OP_PUT;
            if (kind < 40) begin
               pick = $urandom_range(99);
               if (pick < 5)       c.char_code = CH_TAB;
               else if (pick < 10) c.char_code = CH_BACKSPACE;
            end else if (kind < 62) begin
               c.char_code = CH_NEWLINE;
            end else if (kind < 82) begin
               c.opcode = OP_READ;
               pick     = $urandom_range(99);
               base     = shadow_row * COLS + shadow_col;
               if (pick < 50)
                  c.cell_index = 11'((base + CELLS - $urandom_range(200)) % CELLS);
               else if (pick < 85)
                  c.cell_index = 11'($urandom_range(CELLS - 1));
               else
                  c.cell_index = 11'($urandom_range(2047, CELLS));
            end else if (kind < 86) begin
               c.char_code = CH_TAB;
            end else if (kind < 90) begin
               c.char_code = CH_BACKSPACE;
            end else if (kind < 96) begin
               c.opcode = OP_CLEAR;
            end else begin
               c.opcode = OP_UNUSED;
            end
            issue(c, 1'b0, '0, idle_pct);
            sent++;
            // hold off once until the engine has answered everything
            if (hold_mid && sent == items / 2)
               wait_quiet();
         end
      end
   endtask

   // ------------------------------------------------------------- sequence
   initial begin : run_all
      script_row_type s;
      int unsigned    r;
      int unsigned    n;

      // reset contents: every cell 0x0720, cursor home, blank attribute 7
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd0,    1, 1'b1, 16'h0720, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1999, 1, 1'b1, 16'h0720, 0, 0);
      // reads at or past the end of the store, and the unused opcode, return zero
      add_step(OP_READ,  8'hFF, 8'hFF, 4'hF, 11'd2047, 1, 1'b1, 16'h0000, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd2000, 1, 1'b1, 16'h0000, 0, 0);
      add_step(OP_UNUSED, 8'hFF, 8'hFF, 4'hF, 11'd5,   1, 1'b1, 16'h0000, 0, 0);
      // printable puts at the field extremes
      add_step(OP_PUT,   8'h41, 8'h1E, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 1, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd0,    1, 1'b1, 16'h1E41, 1, 0);
      add_step(OP_PUT,   8'hFF, 8'hFF, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 2, 0);
      add_step(OP_PUT,   8'h00, 8'h00, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 3, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1,    1, 1'b1, 16'hFFFF, 3, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd2,    1, 1'b1, 16'h0000, 3, 0);
      // tab, then backspace over a fresh character
      add_step(OP_PUT,   CH_TAB, 8'h00, 4'h0, 11'd0,   1, 1'b1, 16'h0000, 7, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd5,    1, 1'b1, 16'h0720, 7, 0);
      add_step(OP_PUT,   8'h42, 8'h5C, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 8, 0);
      add_step(OP_PUT,   CH_BACKSPACE, 8'h00, 4'h0, 11'd0, 1, 1'b1, 16'h0000, 7, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd7,    1, 1'b1, 16'h0720, 7, 0);
      // newline, then backspace at column 0 stays on the row
      add_step(OP_PUT,   CH_NEWLINE, 8'h00, 4'h0, 11'd0, 1, 1'b1, 16'h0000, 0, 1);
      add_step(OP_PUT,   CH_BACKSPACE, 8'h00, 4'h0, 11'd0, 1, 1'b1, 16'h0000, 0, 1);
      // clear on the brightest and the darkest background
      add_step(OP_CLEAR, 8'h00, 8'h00, 4'hF, 11'd0,    1, 1'b1, 16'h0000, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1999, 1, 1'b1, 16'hF720, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd80,   1, 1'b1, 16'hF720, 0, 0);
      add_step(OP_CLEAR, 8'h00, 8'h00, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 0, 0);
      // mark row 1, walk to the last row, scroll once; the mark lands on row 0
      add_step(OP_PUT,   CH_NEWLINE, 8'h00, 4'h0, 11'd0, 1, 1'b0, '0, 0, 0);
      add_step(OP_PUT,   8'h5A, 8'h2A, 4'h0, 11'd0,    1, 1'b0, '0, 0, 0);
      add_step(OP_PUT,   CH_NEWLINE, 8'h00, 4'h0, 11'd0, 23, 1'b0, '0, 0, 0);
      add_step(OP_PUT,   CH_NEWLINE, 8'h00, 4'h0, 11'd0, 1, 1'b1, 16'h0000, 0, 24);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd0,    1, 1'b1, 16'h2A5A, 0, 24);
      // fill the last row and wrap past column 79 into a scroll
      add_step(OP_PUT,   8'h78, 8'h4E, 4'h0, 11'd0,    79, 1'b0, '0, 0, 0);
      add_step(OP_PUT,   8'h79, 8'h4E, 4'h0, 11'd0,    1, 1'b1, 16'h0000, 0, 24);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1919, 1, 1'b0, '0, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1920, 1, 1'b0, '0, 0, 0);
      // a tab that wraps and scrolls part way through
      add_step(OP_PUT,   8'h77, 8'h13, 4'h0, 11'd0,    78, 1'b0, '0, 0, 0);
      add_step(OP_PUT,   CH_TAB, 8'h00, 4'h0, 11'd0,   1, 1'b0, '0, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1999, 1, 1'b0, '0, 0, 0);
      add_step(OP_READ,  8'h00, 8'h00, 4'h0, 11'd1921, 1, 1'b0, '0, 0, 0);

      // hold reset, then let the clearing pass run
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table back to back
      for (r = 0; r < script.size(); r++) begin
         s = script[r];
         for (n = 0; n < s.reps; n++)
            issue(s.cmd, s.typed, s.want, 0);
      end
      wait_quiet();

      // random phases: one blank attribute and one idle rate each
      write_blank_attr(8'hFF);
      run_traffic(130, 0, 1'b0);
      wait_quiet();
      write_blank_attr(8'h00);
      run_traffic(130, 76, 1'b1);
      wait_quiet();
      write_blank_attr(8'($urandom));
      run_traffic(130, 20, 1'b0);
      wait_quiet();

      if (due_reports.size() != 0) begin
         $error("%0d expected result words never arrived", due_reports.size());
         errors++;
      end
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : testbench

@@ text_console_cell_engine.f @@
src/tcce_pkg.sv
src/tcce_cell_ram.sv
src/tcce_seq.sv
src/text_console_cell_engine.sv
verif/testbench.sv
